@@ hdl/cnl_pkg.sv @@
// types, constants and character tables shared by the cpio name lister
package cnl_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_NAME_PAD,
        PH_DATA,
        PH_DATA_PAD,
        PH_DONE
    } t_phase;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [6:0] MAGIC_LEN       = 7'd6;
    localparam logic [6:0] FSIZE_FIRST_POS = 7'd54;
    localparam logic [6:0] FSIZE_LAST_POS  = 7'd61;
    localparam logic [6:0] NSIZE_FIRST_POS = 7'd94;
    localparam logic [6:0] NSIZE_LAST_POS  = 7'd101;
    localparam logic [6:0] HDR_LAST_POS    = 7'd109;
    localparam logic [3:0] TRAILER_LEN     = 4'd10;
    localparam logic [3:0] NAME_IDX_SAT    = 4'd11;

    typedef struct packed {
        logic [3:0] held_cnt;
        logic       held_last;
        logic       tail_valid;
        logic [1:0] tail_kind;
        logic [7:0] tail_char;
        logic       tail_last;
    } t_burst;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = "0";
            3'd1: c = "7";
            3'd2: c = "0";
            3'd3: c = "7";
            3'd4: c = "0";
            3'd5: c = "1";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0: c = "T";
            4'd1: c = "R";
            4'd2: c = "A";
            4'd3: c = "I";
            4'd4: c = "L";
            4'd5: c = "E";
            4'd6: c = "R";
            4'd7: c = "!";
            4'd8: c = "!";
            4'd9: c = "!";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= "0" && b <= "9") begin
            d = b - 8'h30;
        end else if (b >= "a" && b <= "f") begin
            d = b - 8'h57;
        end else if (b >= "A" && b <= "F") begin
            d = b - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

@@ hdl/cnl_in_if.sv @@
// archive byte channel
interface cnl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] archive_byte;

    modport source (output valid, output archive_byte, input ready);
    modport sink (input valid, input archive_byte, output ready);
endinterface

@@ hdl/cnl_out_if.sv @@
// result channel: name characters and end or error markers
interface cnl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] name_char;
    logic       last_char;

    modport source (output valid, output kind, output name_char, output last_char, input ready);
    modport sink (input valid, input kind, input name_char, input last_char, output ready);
endinterface

@@ hdl/cpio_newc_name_lister_top.sv @@
// Lists the entry names of a newc cpio archive fed one byte per transaction from offset 0.
// A byte that gives results loads them into a result register, which drains one result per
// cycle while the receiver is ready. A byte that ends a held "TRAILER!!!" prefix may give up
// to eleven results. Input is held off while the result register holds results that do not
// all leave in the current cycle; otherwise a byte is taken every cycle that input is valid.
// After an end or magic error result every byte is accepted and dropped until reset. Name
// characters come without the terminator, the last one flagged with last_char.
module cpio_newc_name_lister_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cnl_in_if.sink        i_in,
    cnl_out_if.source     o_out
);

    cnl_pkg::t_phase r_phase, n_phase;
    logic [6:0]      r_pos, n_pos;
    logic [31:0]     r_name_len, n_name_len;
    logic [31:0]     r_data_len, n_data_len;
    logic [31:0]     r_left, n_left;
    logic [1:0]      r_off, n_off;
    logic [3:0]      r_match, n_match;
    logic [3:0]      r_name_idx, n_name_idx;

    logic            r_busy;
    cnl_pkg::t_burst r_burst, n_burst;
    logic [3:0]      r_idx;
    logic            n_emit;

    logic [1:0]      off_n;
    logic [7:0]      in_byte;
    logic            in_fire;
    logic            out_fire;
    logic            cur_held;
    logic            cur_final;
    logic            burst_done;

    assign in_byte = i_in.archive_byte;
    assign off_n   = r_off + 2'd1;
    assign in_fire = i_in.valid & i_in.ready;

    // output side of the result register
    assign cur_held   = r_idx < r_burst.held_cnt;
    assign cur_final  = cur_held ? (!r_burst.tail_valid && r_idx == r_burst.held_cnt - 4'd1)
                                 : 1'b1;
    assign out_fire   = r_busy & o_out.ready;
    assign burst_done = out_fire & cur_final;

    assign i_in.ready      = !r_busy || burst_done;
    assign o_out.valid     = r_busy;
    assign o_out.kind      = cur_held ? cnl_pkg::KIND_NAME : r_burst.tail_kind;
    assign o_out.name_char = cur_held ? cnl_pkg::trailer_char(r_idx) : r_burst.tail_char;
    assign o_out.last_char = cur_held ? (r_burst.held_last && r_idx == r_burst.held_cnt - 4'd1)
                                      : r_burst.tail_last;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_name_len = r_name_len;
        n_data_len = r_data_len;
        n_left     = r_left;
        n_off      = r_off;
        n_match    = r_match;
        n_name_idx = r_name_idx;
        n_burst    = '0;
        n_emit     = 1'b0;

        if (in_fire && r_phase != cnl_pkg::PH_DONE) begin
            n_off = off_n;
            case (r_phase)
                cnl_pkg::PH_HEADER: begin
                    if (r_pos < cnl_pkg::MAGIC_LEN &&
                        in_byte != cnl_pkg::magic_char(r_pos[2:0])) begin
                        n_phase           = cnl_pkg::PH_DONE;
                        n_burst.tail_valid = 1'b1;
                        n_burst.tail_kind  = cnl_pkg::KIND_ERROR;
                        n_emit            = 1'b1;
                    end else begin
                        if (r_pos >= cnl_pkg::FSIZE_FIRST_POS &&
                            r_pos <= cnl_pkg::FSIZE_LAST_POS) begin
                            n_data_len = {r_data_len[27:0], cnl_pkg::hex_digit(in_byte)};
                        end
                        if (r_pos >= cnl_pkg::NSIZE_FIRST_POS &&
                            r_pos <= cnl_pkg::NSIZE_LAST_POS) begin
                            n_name_len = {r_name_len[27:0], cnl_pkg::hex_digit(in_byte)};
                        end
                        if (r_pos == cnl_pkg::HDR_LAST_POS) begin
                            n_pos      = 7'd0;
                            n_match    = 4'd0;
                            n_name_idx = 4'd0;
                            if (r_name_len != 32'd0) begin
                                n_phase = cnl_pkg::PH_NAME;
                                n_left  = r_name_len;
                            end else if (off_n != 2'd0) begin
                                n_phase = cnl_pkg::PH_NAME_PAD;
                            end else if (r_data_len != 32'd0) begin
                                n_phase = cnl_pkg::PH_DATA;
                                n_left  = r_data_len;
                            end else begin
                                n_phase = cnl_pkg::PH_HEADER;
                            end
                        end else begin
                            n_pos = r_pos + 7'd1;
                        end
                    end
                end
                cnl_pkg::PH_NAME: begin
                    if (r_name_idx == cnl_pkg::TRAILER_LEN && r_match == cnl_pkg::TRAILER_LEN &&
                        in_byte == 8'h00) begin
                        n_phase            = cnl_pkg::PH_DONE;
                        n_match            = 4'd0;
                        n_burst.tail_valid = 1'b1;
                        n_burst.tail_kind  = cnl_pkg::KIND_END;
                        n_emit             = 1'b1;
                    end else begin
                        if (r_left >= 32'd2) begin
                            if (r_name_idx < cnl_pkg::TRAILER_LEN && r_match == r_name_idx &&
                                in_byte == cnl_pkg::trailer_char(r_name_idx)) begin
                                n_match = r_match + 4'd1;
                            end else begin
                                n_burst.held_cnt   = r_match;
                                n_burst.tail_valid = 1'b1;
                                n_burst.tail_kind  = cnl_pkg::KIND_NAME;
                                n_burst.tail_char  = in_byte;
                                n_burst.tail_last  = (r_left == 32'd2);
                                n_emit             = 1'b1;
                                n_match            = 4'd0;
                            end
                        end else begin
                            // terminator: release what is held, last one flagged
                            n_burst.held_cnt  = r_match;
                            n_burst.held_last = 1'b1;
                            n_emit            = (r_match != 4'd0);
                            n_match           = 4'd0;
                        end
                        n_left     = r_left - 32'd1;
                        n_name_idx = (r_name_idx == cnl_pkg::NAME_IDX_SAT) ? r_name_idx
                                                                           : r_name_idx + 4'd1;
                        if (r_left == 32'd1) begin
                            if (off_n != 2'd0) begin
                                n_phase = cnl_pkg::PH_NAME_PAD;
                            end else if (r_data_len != 32'd0) begin
                                n_phase = cnl_pkg::PH_DATA;
                                n_left  = r_data_len;
                            end else begin
                                n_phase = cnl_pkg::PH_HEADER;
                                n_pos   = 7'd0;
                            end
                        end
                    end
                end
                cnl_pkg::PH_NAME_PAD: begin
                    if (off_n == 2'd0) begin
                        if (r_data_len != 32'd0) begin
                            n_phase = cnl_pkg::PH_DATA;
                            n_left  = r_data_len;
                        end else begin
                            n_phase = cnl_pkg::PH_HEADER;
                            n_pos   = 7'd0;
                        end
                    end
                end
                cnl_pkg::PH_DATA: begin
                    n_left = r_left - 32'd1;
                    if (r_left == 32'd1) begin
                        if (off_n != 2'd0) begin
                            n_phase = cnl_pkg::PH_DATA_PAD;
                        end else begin
                            n_phase = cnl_pkg::PH_HEADER;
                            n_pos   = 7'd0;
                        end
                    end
                end
                cnl_pkg::PH_DATA_PAD: begin
                    if (off_n == 2'd0) begin
                        n_phase = cnl_pkg::PH_HEADER;
                        n_pos   = 7'd0;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= cnl_pkg::PH_HEADER;
            r_pos      <= 7'd0;
            r_name_len <= 32'd0;
            r_data_len <= 32'd0;
            r_left     <= 32'd0;
            r_off      <= 2'd0;
            r_match    <= 4'd0;
            r_name_idx <= 4'd0;
            r_busy     <= 1'b0;
            r_idx      <= 4'd0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_name_len <= n_name_len;
            r_data_len <= n_data_len;
            r_left     <= n_left;
            r_off      <= n_off;
            r_match    <= n_match;
            r_name_idx <= n_name_idx;
            if (in_fire && n_emit) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (burst_done) begin
                r_busy <= 1'b0;
            end else if (out_fire) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_burst <= n_burst;
        end
    end

endmodule

@@ hdl/cnl_checker.sv @@
// port-level checks for the cpio name lister, bound to the top level
module cnl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_name_char,
    input logic       i_out_last_char
);

    // result codes stay within the defined kinds
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == cnl_pkg::KIND_NAME || i_out_kind == cnl_pkg::KIND_END ||
                         i_out_kind == cnl_pkg::KIND_ERROR))
        else $error("result kind out of range");

    // end and error results carry no character
    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind != cnl_pkg::KIND_NAME) |->
            (i_out_name_char == 8'h00 && !i_out_last_char))
        else $error("end or error result carries a character");

    // nothing follows an end or error transaction
    a_stop_after_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_kind != cnl_pkg::KIND_NAME) |=> !i_out_valid)
        else $error("result after end or error");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_kind) && $stable(i_out_name_char) &&
             $stable(i_out_last_char)))
        else $error("stalled result changed");

endmodule

bind cpio_newc_name_lister_top cnl_checker u_cnl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_kind      (o_out.kind),
    .i_out_name_char (o_out.name_char),
    .i_out_last_char (o_out.last_char)
);
